// ===== hdl/phtk_pkg.sv =====
// shared types and constants for the port histogram with top-k report
package phtk_pkg;

    localparam int PORT_BITS       = 16;
    localparam int ADDR_BITS       = PORT_BITS + 1;
    localparam int MEM_DEPTH       = 2 ** ADDR_BITS;
    localparam int FREQ_BITS       = 32;
    localparam int TOP_BITS        = 4;
    localparam int LIST_SIZE_DEF   = 10;
    localparam int COUNT_BITS_DEF  = 32;

    localparam logic [TOP_BITS-1:0]  TOP_COUNT_RESET = 4'd10;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX        = 32'hFFFF_FFFF;

    localparam logic CMD_COUNT  = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic addr_clr;
        logic addr_inc;
        logic cnt_rd;
        logic cnt_wr;
        logic scan_rd;
        logic list_clear;
        logic emit_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic addr_last;
        logic emit_last;
        logic out_free;
    } ctl_status_t;

endpackage

// ===== hdl/phtk_ctrl.sv =====
// controller state machine: clearing pass, count update, report scan and emit
module phtk_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 command,
    output logic                 item_stall,
    input  phtk_pkg::ctl_status_t status,
    output phtk_pkg::ctl_cmd_t    cmd,
    output phtk_pkg::state_t      state
);
    import phtk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.addr_inc = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (command == CMD_COUNT)
                    begin
                        cmd.cnt_rd = 1'b1;
                        state_next = ST_CNT_WR;
                    end
                    else
                    begin
                        cmd.list_clear = 1'b1;
                        cmd.addr_clr   = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_CNT_WR:
            begin
                cmd.cnt_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.addr_inc = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                // last read word is ranked on this edge
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign state      = state_reg;

endmodule

// ===== hdl/phtk_dpath.sv =====
// datapath: counter memory, scan address, ranked list and result register
module phtk_dpath #(
    parameter int LIST_SIZE  = phtk_pkg::LIST_SIZE_DEF,
    parameter int COUNT_BITS = phtk_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              protocol,
    input  logic [phtk_pkg::PORT_BITS-1:0]    port,
    input  logic                              cfg_we,
    input  logic [phtk_pkg::TOP_BITS-1:0]     cfg_wdata,
    input  phtk_pkg::ctl_cmd_t                cmd,
    output phtk_pkg::ctl_status_t             status,
    input  logic                              res_stall,
    output logic                              res_valid,
    output logic [phtk_pkg::PORT_BITS-1:0]    port_res,
    output logic                              protocol_res,
    output logic [phtk_pkg::FREQ_BITS-1:0]    frequency,
    output logic                              last,
    output logic                              empty_res
);
    import phtk_pkg::*;

    localparam int IDX_W  = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
    localparam int FILL_W = $clog2(LIST_SIZE + 1);
    localparam int LIM_W  = (FILL_W > TOP_BITS) ? FILL_W : TOP_BITS;
    localparam int EXT_W  = (COUNT_BITS > FREQ_BITS) ? COUNT_BITS : FREQ_BITS;

    // counter store
    logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  rd_en;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] sat_inc;

    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  addr_next;
    logic [ADDR_BITS-1:0]  cnt_addr_reg;
    logic [ADDR_BITS-1:0]  ins_addr_reg;
    logic                  ins_valid_reg;

    logic [TOP_BITS-1:0]   top_count_reg;

    // ranked list
    logic [PORT_BITS-1:0]  rank_port_reg [LIST_SIZE];
    logic                  rank_proto_reg [LIST_SIZE];
    logic [COUNT_BITS-1:0] rank_cnt_reg [LIST_SIZE];
    logic [LIST_SIZE-1:0]  lt;
    logic [LIST_SIZE-1:0]  head;
    logic                  do_ins;
    logic [FILL_W-1:0]     fill_reg;

    logic [IDX_W-1:0]      emit_idx_reg;
    logic [LIM_W-1:0]      limit;
    logic [LIM_W-1:0]      fill_ext;
    logic [LIM_W-1:0]      n_out;
    logic                  list_empty;
    logic [EXT_W-1:0]      cnt_ext;
    logic [FREQ_BITS-1:0]  freq_sel;

    logic                  res_valid_reg;
    logic [PORT_BITS-1:0]  port_res_reg;
    logic                  protocol_res_reg;
    logic [FREQ_BITS-1:0]  frequency_reg;
    logic                  last_reg;
    logic                  empty_res_reg;

    assign rd_en   = cmd.cnt_rd | cmd.scan_rd;
    assign rd_addr = cmd.cnt_rd ? {protocol, port} : addr_reg;
    assign wr_en   = cmd.clear_wr | cmd.cnt_wr;
    assign wr_addr = cmd.clear_wr ? addr_reg : cnt_addr_reg;
    assign sat_inc = (&rd_data_reg) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);
    assign wr_data = cmd.clear_wr ? '0 : sat_inc;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_rd)
        begin
            cnt_addr_reg <= {protocol, port};
        end
        if (cmd.scan_rd)
        begin
            ins_addr_reg <= addr_reg;
        end
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.addr_clr)
        begin
            addr_next = '0;
        end
        else if (cmd.addr_inc)
        begin
            addr_next = addr_reg + ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            ins_valid_reg <= 1'b0;
            top_count_reg <= TOP_COUNT_RESET;
        end
        else
        begin
            addr_reg      <= addr_next;
            ins_valid_reg <= cmd.scan_rd;
            if (cfg_we)
            begin
                top_count_reg <= cfg_wdata;
            end
        end
    end

    assign status.addr_last = &addr_reg;

    // entries below the insert point move down one place
    assign do_ins = ins_valid_reg && (rd_data_reg != '0);

    always_comb
    begin
        for (int i = 0; i < LIST_SIZE; i++)
        begin
            lt[i] = rank_cnt_reg[i] < rd_data_reg;
        end
        head[0] = lt[0];
        for (int i = 1; i < LIST_SIZE; i++)
        begin
            head[i] = lt[i] && !lt[i-1];
        end
    end

    for (genvar g = 0; g < LIST_SIZE; g++)
    begin : g_rank
        if (g == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (cmd.list_clear)
                begin
                    rank_cnt_reg[g] <= '0;
                end
                else if (do_ins && lt[g])
                begin
                    rank_cnt_reg[g]   <= rd_data_reg;
                    rank_port_reg[g]  <= ins_addr_reg[PORT_BITS-1:0];
                    rank_proto_reg[g] <= ins_addr_reg[ADDR_BITS-1];
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (cmd.list_clear)
                begin
                    rank_cnt_reg[g] <= '0;
                end
                else if (do_ins && lt[g])
                begin
                    if (head[g])
                    begin
                        rank_cnt_reg[g]   <= rd_data_reg;
                        rank_port_reg[g]  <= ins_addr_reg[PORT_BITS-1:0];
                        rank_proto_reg[g] <= ins_addr_reg[ADDR_BITS-1];
                    end
                    else
                    begin
                        rank_cnt_reg[g]   <= rank_cnt_reg[g-1];
                        rank_port_reg[g]  <= rank_port_reg[g-1];
                        rank_proto_reg[g] <= rank_proto_reg[g-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            if (cmd.list_clear)
            begin
                fill_reg <= '0;
            end
            else if (do_ins && (fill_reg != FILL_W'(LIST_SIZE)))
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.list_clear)
            begin
                emit_idx_reg <= '0;
            end
            else if (cmd.emit_load)
            begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end
        end
    end

    // results per report: top_count, zero read as one, capped at the list size and at the ranked entries held
    always_comb
    begin
        if (top_count_reg == '0)
        begin
            limit = LIM_W'(1);
        end
        else if (LIM_W'(top_count_reg) > LIM_W'(LIST_SIZE))
        begin
            limit = LIM_W'(LIST_SIZE);
        end
        else
        begin
            limit = LIM_W'(top_count_reg);
        end
        fill_ext = LIM_W'(fill_reg);
        n_out    = (fill_ext < limit) ? fill_ext : limit;
    end

    assign list_empty       = (fill_reg == '0);
    assign status.emit_last = list_empty || ((LIM_W'(emit_idx_reg) + LIM_W'(1)) == n_out);
    assign status.out_free  = !res_valid_reg || !res_stall;

    assign cnt_ext  = EXT_W'(rank_cnt_reg[emit_idx_reg]);
    assign freq_sel = (cnt_ext > EXT_W'(FREQ_MAX)) ? FREQ_MAX : FREQ_BITS'(cnt_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            last_reg      <= status.emit_last;
            empty_res_reg <= list_empty;
            if (list_empty)
            begin
                port_res_reg     <= '0;
                protocol_res_reg <= 1'b0;
                frequency_reg    <= '0;
            end
            else
            begin
                port_res_reg     <= rank_port_reg[emit_idx_reg];
                protocol_res_reg <= rank_proto_reg[emit_idx_reg];
                frequency_reg    <= freq_sel;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign port_res     = port_res_reg;
    assign protocol_res = protocol_res_reg;
    assign frequency    = frequency_reg;
    assign last         = last_reg;
    assign empty_res    = empty_res_reg;

endmodule

// ===== hdl/port_histogram_top_k.sv =====
// port hit histogram with top-k report: a count item is read, then written back
// a report scans all 131072 counters of the counter memory, one read a cycle,
// then emits one result beat per cycle while the result side does not stall
// items are held off during a report scan and emit; results wait in an output register
// after reset a clearing pass writes zero to all 131072 counters, one a cycle,
// with item_stall high; configuration writes are taken throughout
module port_histogram_top_k #(
    parameter int LIST_SIZE  = phtk_pkg::LIST_SIZE_DEF,
    parameter int COUNT_BITS = phtk_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [phtk_pkg::TOP_BITS-1:0]     cfg_wdata,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              command,
    input  logic                              protocol,
    input  logic [phtk_pkg::PORT_BITS-1:0]    port,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [phtk_pkg::PORT_BITS-1:0]    port_res,
    output logic                              protocol_res,
    output logic [phtk_pkg::FREQ_BITS-1:0]    frequency,
    output logic                              last,
    output logic                              empty_res
);
    import phtk_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;
    state_t      state;

    phtk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (command),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd),
        .state      (state)
    );

    phtk_dpath #(
        .LIST_SIZE  (LIST_SIZE),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .protocol     (protocol),
        .port         (port),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status),
        .res_stall    (res_stall),
        .res_valid    (res_valid),
        .port_res     (port_res),
        .protocol_res (protocol_res),
        .frequency    (frequency),
        .last         (last),
        .empty_res    (empty_res)
    );

`ifndef SYNTH
    // a new result beat only comes out of the emit phase
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state) == ST_EMIT)
        else $error("result beat raised outside emit");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && empty_res |-> last && (frequency == '0) && (port_res == '0))
        else $error("empty report beat malformed");

    a_ranked_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !empty_res |-> frequency != '0)
        else $error("ranked beat with zero count");

    a_count_wb: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (command == CMD_COUNT) |=> state == ST_CNT_WR)
        else $error("count beat without write back");
`endif

endmodule
